[rtl/rvcls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IMA instruction classifier package
// Instruction ids, major opcodes, function codes and the decode tables
// used by the classifier modules.
// ----------------------------------------------------------------------------
package rvcls_pkg;

  localparam int WordW = 32;
  localparam int IdW   = 7;

  typedef logic [IdW-1:0] instr_id_t;

  localparam instr_id_t ID_ILLEGAL   = 7'd0;
  localparam instr_id_t ID_LB        = 7'd1;
  localparam instr_id_t ID_LH        = 7'd2;
  localparam instr_id_t ID_LW        = 7'd3;
  localparam instr_id_t ID_LBU       = 7'd4;
  localparam instr_id_t ID_LHU       = 7'd5;
  localparam instr_id_t ID_FENCE     = 7'd6;
  localparam instr_id_t ID_FENCE_I   = 7'd7;
  localparam instr_id_t ID_ADDI      = 7'd8;
  localparam instr_id_t ID_SLLI      = 7'd9;
  localparam instr_id_t ID_SLTI      = 7'd10;
  localparam instr_id_t ID_SLTIU     = 7'd11;
  localparam instr_id_t ID_XORI      = 7'd12;
  localparam instr_id_t ID_SRLI      = 7'd13;
  localparam instr_id_t ID_SRAI      = 7'd14;
  localparam instr_id_t ID_ORI       = 7'd15;
  localparam instr_id_t ID_ANDI      = 7'd16;
  localparam instr_id_t ID_AUIPC     = 7'd17;
  localparam instr_id_t ID_SB        = 7'd18;
  localparam instr_id_t ID_SH        = 7'd19;
  localparam instr_id_t ID_SW        = 7'd20;
  localparam instr_id_t ID_AMOADD_W  = 7'd21;
  localparam instr_id_t ID_AMOSWAP_W = 7'd22;
  localparam instr_id_t ID_LR_W      = 7'd23;
  localparam instr_id_t ID_SC_W      = 7'd24;
  localparam instr_id_t ID_AMOXOR_W  = 7'd25;
  localparam instr_id_t ID_AMOOR_W   = 7'd26;
  localparam instr_id_t ID_AMOAND_W  = 7'd27;
  localparam instr_id_t ID_AMOMIN_W  = 7'd28;
  localparam instr_id_t ID_AMOMAX_W  = 7'd29;
  localparam instr_id_t ID_AMOMINU_W = 7'd30;
  localparam instr_id_t ID_AMOMAXU_W = 7'd31;
  localparam instr_id_t ID_ADD       = 7'd32;
  localparam instr_id_t ID_SLL       = 7'd33;
  localparam instr_id_t ID_SLT       = 7'd34;
  localparam instr_id_t ID_SLTU      = 7'd35;
  localparam instr_id_t ID_XOR       = 7'd36;
  localparam instr_id_t ID_SRL       = 7'd37;
  localparam instr_id_t ID_OR        = 7'd38;
  localparam instr_id_t ID_AND       = 7'd39;
  localparam instr_id_t ID_SUB       = 7'd40;
  localparam instr_id_t ID_SRA       = 7'd41;
  localparam instr_id_t ID_MUL       = 7'd42;
  localparam instr_id_t ID_MULH      = 7'd43;
  localparam instr_id_t ID_MULHSU    = 7'd44;
  localparam instr_id_t ID_MULHU     = 7'd45;
  localparam instr_id_t ID_DIV       = 7'd46;
  localparam instr_id_t ID_DIVU      = 7'd47;
  localparam instr_id_t ID_REM       = 7'd48;
  localparam instr_id_t ID_REMU      = 7'd49;
  localparam instr_id_t ID_LUI       = 7'd50;
  localparam instr_id_t ID_BEQ       = 7'd51;
  localparam instr_id_t ID_BNE       = 7'd52;
  localparam instr_id_t ID_BLT       = 7'd53;
  localparam instr_id_t ID_BGE       = 7'd54;
  localparam instr_id_t ID_BLTU      = 7'd55;
  localparam instr_id_t ID_BGEU      = 7'd56;
  localparam instr_id_t ID_JALR      = 7'd57;
  localparam instr_id_t ID_JAL       = 7'd58;
  localparam instr_id_t ID_ECALL     = 7'd59;
  localparam instr_id_t ID_EBREAK    = 7'd60;
  localparam instr_id_t ID_CSRRW     = 7'd61;
  localparam instr_id_t ID_CSRRS     = 7'd62;
  localparam instr_id_t ID_CSRRC     = 7'd63;
  localparam instr_id_t ID_CSRRWI    = 7'd64;
  localparam instr_id_t ID_CSRRSI    = 7'd65;
  localparam instr_id_t ID_CSRRCI    = 7'd66;
  localparam instr_id_t ID_LAST      = ID_CSRRCI;

  localparam logic [1:0] LEN_32BIT = 2'b11;

  localparam logic [4:0] OP_LOAD     = 5'h00;
  localparam logic [4:0] OP_MISC_MEM = 5'h03;
  localparam logic [4:0] OP_OP_IMM   = 5'h04;
  localparam logic [4:0] OP_AUIPC    = 5'h05;
  localparam logic [4:0] OP_STORE    = 5'h08;
  localparam logic [4:0] OP_AMO      = 5'h0b;
  localparam logic [4:0] OP_OP       = 5'h0c;
  localparam logic [4:0] OP_LUI      = 5'h0d;
  localparam logic [4:0] OP_BRANCH   = 5'h18;
  localparam logic [4:0] OP_JALR     = 5'h19;
  localparam logic [4:0] OP_JAL      = 5'h1b;
  localparam logic [4:0] OP_SYSTEM   = 5'h1c;

  localparam logic [2:0] F3_ADD    = 3'd0;
  localparam logic [2:0] F3_SLL    = 3'd1;
  localparam logic [2:0] F3_AMO_W  = 3'd2;
  localparam logic [2:0] F3_SR     = 3'd5;
  localparam logic [2:0] F3_FENCE  = 3'd0;
  localparam logic [2:0] F3_FENCEI = 3'd1;
  localparam logic [2:0] F3_PRIV   = 3'd0;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [4:0]  AMO_LR     = 5'h02;
  localparam logic [11:0] IMM_ECALL  = 12'h000;
  localparam logic [11:0] IMM_EBREAK = 12'h001;

  localparam instr_id_t LOAD_IDS [8] = '{
    ID_LB, ID_LH, ID_LW, ID_ILLEGAL, ID_LBU, ID_LHU, ID_ILLEGAL, ID_ILLEGAL
  };
  localparam instr_id_t STORE_IDS [8] = '{
    ID_SB, ID_SH, ID_SW, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL
  };
  localparam instr_id_t IMM_IDS [8] = '{
    ID_ADDI, ID_SLLI, ID_SLTI, ID_SLTIU, ID_XORI, ID_SRLI, ID_ORI, ID_ANDI
  };
  localparam instr_id_t ALU_IDS [8] = '{
    ID_ADD, ID_SLL, ID_SLT, ID_SLTU, ID_XOR, ID_SRL, ID_OR, ID_AND
  };
  localparam instr_id_t MULDIV_IDS [8] = '{
    ID_MUL, ID_MULH, ID_MULHSU, ID_MULHU, ID_DIV, ID_DIVU, ID_REM, ID_REMU
  };
  localparam instr_id_t BRANCH_IDS [8] = '{
    ID_BEQ, ID_BNE, ID_ILLEGAL, ID_ILLEGAL, ID_BLT, ID_BGE, ID_BLTU, ID_BGEU
  };
  localparam instr_id_t CSR_IDS [8] = '{
    ID_ILLEGAL, ID_CSRRW, ID_CSRRS, ID_CSRRC,
    ID_ILLEGAL, ID_CSRRWI, ID_CSRRSI, ID_CSRRCI
  };
  localparam instr_id_t AMO_IDS [32] = '{
    ID_AMOADD_W, ID_AMOSWAP_W, ID_LR_W, ID_SC_W,
    ID_AMOXOR_W, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL,
    ID_AMOOR_W, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL,
    ID_AMOAND_W, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL,
    ID_AMOMIN_W, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL,
    ID_AMOMAX_W, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL,
    ID_AMOMINU_W, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL,
    ID_AMOMAXU_W, ID_ILLEGAL, ID_ILLEGAL, ID_ILLEGAL
  };

endpackage
`default_nettype wire

[rtl/rv32ima_instruction_classifier_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IMA instruction classifier, top level
// Registers each instruction word, decodes it and registers the result.
// ----------------------------------------------------------------------------
// The classifier takes one 32-bit instruction word per transfer and returns
// one result per word, in order: a dense instruction id from 0 to 66 and an
// illegal flag that is set exactly when the id is 0. The result of a word
// passes through the input register and then the result register before it
// appears on the output. While the output is not stalled a new word can be
// taken in every cycle, so the sustained rate is one instruction per cycle;
// the single field decoder between the two registers is combinational and
// does not limit that rate. When the output is stalled the two registers
// fill and the input stops taking words until a result leaves.
module rv32ima_instruction_classifier_top
  import rvcls_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WordW-1:0] instruction_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output instr_id_t             instruction_id,
  output logic                  is_illegal
);

  logic             s1_valid;
  logic [WordW-1:0] s1_word;
  logic             s1_adv;
  instr_id_t        dec_id;
  logic             dec_illegal;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= instruction_word;
    end
  end

  rvcls_decode u_decode (
    .word    (s1_word),
    .id      (dec_id),
    .illegal (dec_illegal)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      instruction_id <= dec_id;
      is_illegal     <= dec_illegal;
    end
  end

  a_flag_matches_id: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_illegal == (instruction_id == ID_ILLEGAL)))
    else $error("illegal flag disagrees with the instruction id");

  a_id_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (instruction_id <= ID_LAST))
    else $error("instruction id beyond the last defined id");

  a_input_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted word did not reach the decode stage");

  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (out_valid && instruction_id == $past(dec_id)))
    else $error("decoded result was not captured in the result register");

endmodule
`default_nettype wire

[rtl/rvcls_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IMA instruction field decoder
// Matches the fields of one instruction word against the supported
// encodings and gives the dense instruction id and the illegal flag.
// ----------------------------------------------------------------------------
module rvcls_decode
  import rvcls_pkg::*;
(
  input  wire logic [WordW-1:0] word,
  output instr_id_t             id,
  output logic                  illegal
);

  logic [4:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [11:0] imm;
  logic [4:0]  amo_top;

  assign op      = word[6:2];
  assign f3      = word[14:12];
  assign f7      = word[31:25];
  assign rd      = word[11:7];
  assign rs1     = word[19:15];
  assign rs2     = word[24:20];
  assign imm     = word[31:20];
  assign amo_top = word[31:27];

  always_comb begin
    id = ID_ILLEGAL;
    if (word[1:0] == LEN_32BIT) begin
      unique case (op)
        OP_LOAD: begin
          id = LOAD_IDS[f3];
        end
        OP_MISC_MEM: begin
          if (rd == 5'd0 && rs1 == 5'd0) begin
            if (f3 == F3_FENCE) begin
              id = ID_FENCE;
            end else if (f3 == F3_FENCEI) begin
              id = ID_FENCE_I;
            end
          end
        end
        OP_OP_IMM: begin
          if (f3 == F3_SLL) begin
            if (f7 == F7_BASE) begin
              id = ID_SLLI;
            end
          end else if (f3 == F3_SR) begin
            if (f7 == F7_BASE) begin
              id = ID_SRLI;
            end else if (f7 == F7_ALT) begin
              id = ID_SRAI;
            end
          end else begin
            id = IMM_IDS[f3];
          end
        end
        OP_AUIPC: begin
          id = ID_AUIPC;
        end
        OP_STORE: begin
          id = STORE_IDS[f3];
        end
        OP_AMO: begin
          if (f3 == F3_AMO_W && (amo_top != AMO_LR || rs2 == 5'd0)) begin
            id = AMO_IDS[amo_top];
          end
        end
        OP_OP: begin
          if (f7 == F7_BASE) begin
            id = ALU_IDS[f3];
          end else if (f7 == F7_MULDIV) begin
            id = MULDIV_IDS[f3];
          end else if (f7 == F7_ALT) begin
            if (f3 == F3_ADD) begin
              id = ID_SUB;
            end else if (f3 == F3_SR) begin
              id = ID_SRA;
            end
          end
        end
        OP_LUI: begin
          id = ID_LUI;
        end
        OP_BRANCH: begin
          id = BRANCH_IDS[f3];
        end
        OP_JALR: begin
          if (f3 == F3_ADD) begin
            id = ID_JALR;
          end
        end
        OP_JAL: begin
          id = ID_JAL;
        end
        OP_SYSTEM: begin
          if (f3 == F3_PRIV) begin
            if (rd == 5'd0 && rs1 == 5'd0) begin
              if (imm == IMM_ECALL) begin
                id = ID_ECALL;
              end else if (imm == IMM_EBREAK) begin
                id = ID_EBREAK;
              end
            end
          end else begin
            id = CSR_IDS[f3];
          end
        end
        default: begin
          id = ID_ILLEGAL;
        end
      endcase
    end
  end

  assign illegal = (id == ID_ILLEGAL);

endmodule
`default_nettype wire
